>>> src/assert_macros.svh
// Assertion macros used by the checker file of the lexer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");

`endif

>>> src/stl_pkg.sv
// Shared constants and types for the source text lexer.
// No dependencies; used by every module of the block.
package stl_pkg;

    localparam int CHAR_W            = 21;
    localparam int KIND_W            = 6;
    localparam int MAX_TOKEN_LEN_DEF = 64;
    localparam int MAX_LINE_LEN_DEF  = 4096;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [KIND_W-1:0] KIND_EOF      = 6'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 6'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 6'd2;
    localparam logic [KIND_W-1:0] KIND_STRING   = 6'd3;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 6'd4;
    localparam logic [KIND_W-1:0] KIND_EQ       = 6'd5;
    localparam logic [KIND_W-1:0] KIND_NOT      = 6'd6;
    localparam logic [KIND_W-1:0] KIND_NE       = 6'd7;
    localparam logic [KIND_W-1:0] KIND_HASH     = 6'd8;
    localparam logic [KIND_W-1:0] KIND_LT       = 6'd9;
    localparam logic [KIND_W-1:0] KIND_LE       = 6'd10;
    localparam logic [KIND_W-1:0] KIND_GT       = 6'd11;
    localparam logic [KIND_W-1:0] KIND_GE       = 6'd12;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 6'd13;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 6'd14;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 6'd15;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 6'd16;
    localparam logic [KIND_W-1:0] KIND_LBRACK   = 6'd17;
    localparam logic [KIND_W-1:0] KIND_RBRACK   = 6'd18;
    localparam logic [KIND_W-1:0] KIND_COLON    = 6'd19;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 6'd20;
    localparam logic [KIND_W-1:0] KIND_DOT      = 6'd21;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 6'd22;
    localparam logic [KIND_W-1:0] KIND_OR       = 6'd23;
    localparam logic [KIND_W-1:0] KIND_LOR      = 6'd24;
    localparam logic [KIND_W-1:0] KIND_AND      = 6'd25;
    localparam logic [KIND_W-1:0] KIND_LAND     = 6'd26;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 6'd27;
    localparam logic [KIND_W-1:0] KIND_PLUS_EQ  = 6'd28;
    localparam logic [KIND_W-1:0] KIND_INC      = 6'd29;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 6'd30;
    localparam logic [KIND_W-1:0] KIND_MINUS_EQ = 6'd31;
    localparam logic [KIND_W-1:0] KIND_DEC      = 6'd32;
    localparam logic [KIND_W-1:0] KIND_STAR     = 6'd33;
    localparam logic [KIND_W-1:0] KIND_STAR_EQ  = 6'd34;
    localparam logic [KIND_W-1:0] KIND_POW      = 6'd35;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 6'd36;
    localparam logic [KIND_W-1:0] KIND_SLASH_EQ = 6'd37;
    localparam logic [KIND_W-1:0] KIND_SYMBOL   = 6'd38;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 6'd39;
    localparam logic [KIND_W-1:0] KIND_UNTERM   = 6'd40;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> src/stl_front.sv
// Front end of the lexer: classifies each character and runs the token state machine.
// Depends on stl_pkg; pushes at most one queue entry of one or two token records per transaction.
module stl_front #(
    parameter int MAX_TOKEN_LEN = stl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int MAX_LINE_LEN  = stl_pkg::MAX_LINE_LEN_DEF,
    parameter int LEN_W         = $clog2(MAX_TOKEN_LEN + 1),
    parameter int POS_W         = $clog2(MAX_LINE_LEN + 1),
    parameter int REC_W         = stl_pkg::KIND_W + LEN_W + POS_W + 1,
    parameter int ENTRY_W       = 2 * REC_W + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [stl_pkg::CHAR_W-1:0]  char_code,
    output logic                        push,
    output logic [ENTRY_W-1:0]          entry
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_OP
    } mode_t;

    localparam logic [stl_pkg::KIND_W-1:0] KIND_NONE = '0;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE_LEN);

    localparam logic [20:0] CH_NUL    = 21'h00;
    localparam logic [20:0] CH_TAB    = 21'h09;
    localparam logic [20:0] CH_CR     = 21'h0D;
    localparam logic [20:0] CH_SPACE  = 21'h20;
    localparam logic [20:0] CH_BANG   = 21'h21;
    localparam logic [20:0] CH_QUOTE  = 21'h22;
    localparam logic [20:0] CH_HASH   = 21'h23;
    localparam logic [20:0] CH_AMP    = 21'h26;
    localparam logic [20:0] CH_LPAREN = 21'h28;
    localparam logic [20:0] CH_RPAREN = 21'h29;
    localparam logic [20:0] CH_STAR   = 21'h2A;
    localparam logic [20:0] CH_PLUS   = 21'h2B;
    localparam logic [20:0] CH_COMMA  = 21'h2C;
    localparam logic [20:0] CH_MINUS  = 21'h2D;
    localparam logic [20:0] CH_DOT    = 21'h2E;
    localparam logic [20:0] CH_SLASH  = 21'h2F;
    localparam logic [20:0] CH_ZERO   = 21'h30;
    localparam logic [20:0] CH_NINE   = 21'h39;
    localparam logic [20:0] CH_COLON  = 21'h3A;
    localparam logic [20:0] CH_SEMI   = 21'h3B;
    localparam logic [20:0] CH_LT     = 21'h3C;
    localparam logic [20:0] CH_EQ     = 21'h3D;
    localparam logic [20:0] CH_GT     = 21'h3E;
    localparam logic [20:0] CH_AT     = 21'h40;
    localparam logic [20:0] CH_UP_A   = 21'h41;
    localparam logic [20:0] CH_UP_Z   = 21'h5A;
    localparam logic [20:0] CH_LBRACK = 21'h5B;
    localparam logic [20:0] CH_RBRACK = 21'h5D;
    localparam logic [20:0] CH_UNDER  = 21'h5F;
    localparam logic [20:0] CH_BTICK  = 21'h60;
    localparam logic [20:0] CH_LO_A   = 21'h61;
    localparam logic [20:0] CH_LO_F   = 21'h66;
    localparam logic [20:0] CH_LO_Z   = 21'h7A;
    localparam logic [20:0] CH_LBRACE = 21'h7B;
    localparam logic [20:0] CH_PIPE   = 21'h7C;
    localparam logic [20:0] CH_RBRACE = 21'h7D;
    localparam logic [20:0] CH_TILDE  = 21'h7E;

    function automatic logic [stl_pkg::KIND_W-1:0] single_kind(input logic [20:0] c);
        logic [stl_pkg::KIND_W-1:0] k;
        case (c)
            CH_EQ:     k = stl_pkg::KIND_ASSIGN;
            CH_BANG:   k = stl_pkg::KIND_NOT;
            CH_HASH:   k = stl_pkg::KIND_HASH;
            CH_LT:     k = stl_pkg::KIND_LT;
            CH_GT:     k = stl_pkg::KIND_GT;
            CH_LPAREN: k = stl_pkg::KIND_LPAREN;
            CH_RPAREN: k = stl_pkg::KIND_RPAREN;
            CH_LBRACE: k = stl_pkg::KIND_LBRACE;
            CH_RBRACE: k = stl_pkg::KIND_RBRACE;
            CH_LBRACK: k = stl_pkg::KIND_LBRACK;
            CH_RBRACK: k = stl_pkg::KIND_RBRACK;
            CH_COLON:  k = stl_pkg::KIND_COLON;
            CH_SEMI:   k = stl_pkg::KIND_SEMI;
            CH_DOT:    k = stl_pkg::KIND_DOT;
            CH_COMMA:  k = stl_pkg::KIND_COMMA;
            CH_PIPE:   k = stl_pkg::KIND_OR;
            CH_AMP:    k = stl_pkg::KIND_AND;
            CH_PLUS:   k = stl_pkg::KIND_PLUS;
            CH_MINUS:  k = stl_pkg::KIND_MINUS;
            CH_STAR:   k = stl_pkg::KIND_STAR;
            CH_SLASH:  k = stl_pkg::KIND_SLASH;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic needs_lookahead(input logic [stl_pkg::KIND_W-1:0] k);
        logic r;
        case (k)
            stl_pkg::KIND_ASSIGN, stl_pkg::KIND_NOT, stl_pkg::KIND_LT, stl_pkg::KIND_GT,
            stl_pkg::KIND_OR, stl_pkg::KIND_AND, stl_pkg::KIND_PLUS, stl_pkg::KIND_MINUS,
            stl_pkg::KIND_STAR, stl_pkg::KIND_SLASH: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [stl_pkg::KIND_W-1:0] pair_kind(
        input logic [stl_pkg::KIND_W-1:0] k,
        input logic [20:0]                c
    );
        logic [stl_pkg::KIND_W-1:0] r;
        logic                       eq;
        eq = (c == CH_EQ);
        r  = KIND_NONE;
        case (k)
            stl_pkg::KIND_ASSIGN: r = eq ? stl_pkg::KIND_EQ : KIND_NONE;
            stl_pkg::KIND_NOT:    r = eq ? stl_pkg::KIND_NE : KIND_NONE;
            stl_pkg::KIND_LT:     r = eq ? stl_pkg::KIND_LE : KIND_NONE;
            stl_pkg::KIND_GT:     r = eq ? stl_pkg::KIND_GE : KIND_NONE;
            stl_pkg::KIND_SLASH:  r = eq ? stl_pkg::KIND_SLASH_EQ : KIND_NONE;
            stl_pkg::KIND_OR:     r = (c == CH_PIPE) ? stl_pkg::KIND_LOR : KIND_NONE;
            stl_pkg::KIND_AND:    r = (c == CH_AMP) ? stl_pkg::KIND_LAND : KIND_NONE;
            stl_pkg::KIND_PLUS:
                r = eq ? stl_pkg::KIND_PLUS_EQ :
                    ((c == CH_PLUS) ? stl_pkg::KIND_INC : KIND_NONE);
            stl_pkg::KIND_MINUS:
                r = eq ? stl_pkg::KIND_MINUS_EQ :
                    ((c == CH_MINUS) ? stl_pkg::KIND_DEC : KIND_NONE);
            stl_pkg::KIND_STAR:
                r = eq ? stl_pkg::KIND_STAR_EQ :
                    ((c == CH_STAR) ? stl_pkg::KIND_POW : KIND_NONE);
            default: r = KIND_NONE;
        endcase
        return r;
    endfunction

    mode_t                      mode_reg, mode_next;
    logic [stl_pkg::KIND_W-1:0] pend_reg, pend_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       ovf_reg, ovf_next;

    logic                       is_alpha, is_digit, is_space, is_quote, is_special;
    logic [stl_pkg::KIND_W-1:0] sk, pk;
    logic [POS_W-1:0]           nx;
    logic [LEN_W-1:0]           app_len;
    logic                       app_ovf;

    logic                       st_v, st_begin, st_op;
    mode_t                      st_mode;
    logic [REC_W-1:0]           st_rec;

    logic                       pre_v, post_v, use_start;
    logic [REC_W-1:0]           pre_rec, post_rec;

    always_comb
    begin
        is_alpha   = ((char_code >= CH_UP_A) && (char_code <= CH_UP_Z)) ||
                     ((char_code >= CH_LO_A) && (char_code <= CH_LO_Z));
        is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_space   = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
        is_quote   = (char_code == CH_QUOTE);
        is_special = (char_code != CH_UNDER) &&
                     (((char_code >= CH_BANG) && (char_code <= CH_SLASH)) ||
                      ((char_code >= CH_COLON) && (char_code <= CH_AT)) ||
                      ((char_code >= CH_LBRACK) && (char_code <= CH_BTICK)) ||
                      ((char_code >= CH_LBRACE) && (char_code <= CH_TILDE)));
        sk = single_kind(char_code);
        pk = pair_kind(pend_reg, char_code);

        nx      = (pos_reg != POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        app_len = (len_reg != LEN_MAX) ? len_reg + LEN_W'(1) : len_reg;
        app_ovf = ovf_reg | (len_reg == LEN_MAX);

        // Outcome of a character seen with no token pending.
        st_v     = 1'b0;
        st_begin = 1'b0;
        st_op    = 1'b0;
        st_mode  = MODE_IDLE;
        st_rec   = {stl_pkg::KIND_UNKNOWN, LEN_ONE, nx, 1'b0};
        if (is_space) begin
            st_v = 1'b0;
        end else if (is_alpha) begin
            st_mode  = MODE_IDENT;
            st_begin = 1'b1;
        end else if (is_digit) begin
            st_mode  = MODE_NUMBER;
            st_begin = 1'b1;
        end else if (is_quote) begin
            st_mode  = MODE_STRING;
            st_begin = 1'b1;
        end else if (is_special) begin
            if (sk == KIND_NONE) begin
                st_v   = 1'b1;
                st_rec = {stl_pkg::KIND_SYMBOL, LEN_ONE, nx, 1'b0};
            end else if (needs_lookahead(sk)) begin
                st_mode  = MODE_OP;
                st_begin = 1'b1;
                st_op    = 1'b1;
            end else begin
                st_v   = 1'b1;
                st_rec = {sk, LEN_ONE, nx, 1'b0};
            end
        end else begin
            st_v = 1'b1;
        end

        pre_v     = 1'b0;
        pre_rec   = {stl_pkg::KIND_EOF, {LEN_W{1'b0}}, pos_reg, 1'b0};
        use_start = 1'b0;
        mode_next = mode_reg;
        pend_next = pend_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        pos_next  = nx;

        if (char_code == CH_NUL) begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    pre_v   = 1'b1;
                    pre_rec = {stl_pkg::KIND_IDENT, len_reg, pos_reg, ovf_reg};
                end
                MODE_NUMBER:
                begin
                    pre_v   = 1'b1;
                    pre_rec = {stl_pkg::KIND_NUMBER, len_reg, pos_reg, ovf_reg};
                end
                MODE_STRING:
                begin
                    pre_v   = 1'b1;
                    pre_rec = {stl_pkg::KIND_UNTERM, len_reg, pos_reg, ovf_reg};
                end
                MODE_OP:
                begin
                    pre_v   = 1'b1;
                    pre_rec = {pend_reg, LEN_ONE, pos_reg, 1'b0};
                end
                default:
                begin
                    pre_v = 1'b0;
                end
            endcase
            mode_next = MODE_IDLE;
            pend_next = '0;
            len_next  = '0;
            ovf_next  = 1'b0;
            pos_next  = '0;
        end else begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alpha || is_digit || (char_code == CH_UNDER)) begin
                        len_next = app_len;
                        ovf_next = app_ovf;
                    end else begin
                        pre_v     = 1'b1;
                        pre_rec   = {stl_pkg::KIND_IDENT, len_reg, pos_reg, ovf_reg};
                        use_start = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit || (char_code == CH_DOT) || (char_code == CH_LO_F)) begin
                        len_next = app_len;
                        ovf_next = app_ovf;
                    end else begin
                        pre_v     = 1'b1;
                        pre_rec   = {stl_pkg::KIND_NUMBER, len_reg, pos_reg, ovf_reg};
                        use_start = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    len_next = app_len;
                    ovf_next = app_ovf;
                    if (is_quote) begin
                        pre_v     = 1'b1;
                        pre_rec   = {stl_pkg::KIND_STRING, app_len, nx, app_ovf};
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_OP:
                begin
                    pre_v = 1'b1;
                    if (pk != KIND_NONE) begin
                        pre_rec   = {pk, LEN_TWO, nx, 1'b0};
                        mode_next = MODE_IDLE;
                    end else begin
                        pre_rec   = {pend_reg, LEN_ONE, pos_reg, 1'b0};
                        use_start = 1'b1;
                    end
                end
                default:
                begin
                    use_start = 1'b1;
                end
            endcase
            if (use_start) begin
                mode_next = st_mode;
                if (st_begin) begin
                    len_next = LEN_ONE;
                    ovf_next = 1'b0;
                end
                if (st_op) begin
                    pend_next = sk;
                end
            end
        end

        post_v   = (char_code == CH_NUL) ? 1'b1 : (use_start & st_v);
        post_rec = (char_code == CH_NUL) ? {stl_pkg::KIND_EOF, {LEN_W{1'b0}}, pos_reg, 1'b0}
                                         : st_rec;

        push  = accept & (pre_v | post_v);
        entry = pre_v ? {post_v, pre_rec, post_rec} : {1'b0, post_rec, post_rec};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            pend_reg <= '0;
            len_reg  <= '0;
            pos_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

>>> src/stl_queue.sv
// Short queue between the front and back ends of the lexer.
// Depends on stl_pkg for the status struct.
module stl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = stl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rd_data,
    output stl_pkg::q_stat_t     stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_comb
    begin
        stat.full  = (cnt_reg == CNT_W'(DEPTH));
        stat.empty = (cnt_reg == '0);
        rd_data    = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> src/stl_back.sv
// Back end of the lexer: takes queue entries and delivers their token records one per transaction.
// Depends on stl_pkg; marks the final record of each character with last.
module stl_back #(
    parameter int LEN_W   = 7,
    parameter int POS_W   = 13,
    parameter int REC_W   = stl_pkg::KIND_W + LEN_W + POS_W + 1,
    parameter int ENTRY_W = 2 * REC_W + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stl_pkg::q_stat_t            stat,
    input  logic [ENTRY_W-1:0]          rd_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [stl_pkg::KIND_W-1:0]  token_kind,
    output logic [LEN_W-1:0]            token_length,
    output logic [POS_W-1:0]            end_position,
    output logic                        truncated,
    output logic                        last
);

    logic [ENTRY_W-1:0] hold_reg;
    logic               valid_reg;
    logic               second_reg;
    logic               has_second;
    logic               advance;
    logic [REC_W-1:0]   rec;

    always_comb
    begin
        has_second = hold_reg[ENTRY_W-1];
        rec        = second_reg ? hold_reg[REC_W-1:0] : hold_reg[2*REC_W-1:REC_W];
        advance    = valid_reg && out_ready && !second_reg && has_second;
        pop        = !stat.empty && (!valid_reg || (out_ready && !advance));
        {token_kind, token_length, end_position, truncated} = rec;
        last       = second_reg | ~has_second;
        out_valid  = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else if (advance) begin
            second_reg <= 1'b1;
        end else if (pop) begin
            valid_reg  <= 1'b1;
            second_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            hold_reg <= rd_data;
        end
    end

endmodule

>>> src/source_text_lexer_core.sv
// Source text lexer: takes one character of a line per transaction and delivers token records.
// One character is accepted every cycle while the four-entry queue between the classifying
// front end and the record-delivering back end has room; a character that ends one token and
// is a complete token itself yields two records, delivered one after the other, so the sustained
// rate is one character per cycle when each yields at most one record and out_ready stays high.
// With the queue and output empty, a record passes through the queue memory and then the back
// end's hold register before it appears on the output. A zero character ends the line: any
// pending token is flushed, an EOF record follows, and the position restarts at zero.
module source_text_lexer_core #(
    parameter int MAX_TOKEN_LEN = stl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int MAX_LINE_LEN  = stl_pkg::MAX_LINE_LEN_DEF,
    parameter int LEN_W         = $clog2(MAX_TOKEN_LEN + 1),
    parameter int POS_W         = $clog2(MAX_LINE_LEN + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [stl_pkg::CHAR_W-1:0]  char_code,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [stl_pkg::KIND_W-1:0]  token_kind,
    output logic [LEN_W-1:0]            token_length,
    output logic [POS_W-1:0]            end_position,
    output logic                        truncated,
    output logic                        last
);

    localparam int REC_W   = stl_pkg::KIND_W + LEN_W + POS_W + 1;
    localparam int ENTRY_W = 2 * REC_W + 1;

    logic               accept;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    stl_pkg::q_stat_t   stat;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    stl_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .MAX_LINE_LEN  (MAX_LINE_LEN),
        .LEN_W         (LEN_W),
        .POS_W         (POS_W),
        .REC_W         (REC_W),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (char_code),
        .push      (push),
        .entry     (wr_entry)
    );

    stl_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (stl_pkg::QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .stat    (stat)
    );

    stl_back #(
        .LEN_W   (LEN_W),
        .POS_W   (POS_W),
        .REC_W   (REC_W),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (stat),
        .rd_data      (rd_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_length (token_length),
        .end_position (end_position),
        .truncated    (truncated),
        .last         (last)
    );

endmodule

>>> src/stl_checker.sv
// Port-level checks for the source text lexer, attached to the top level by bind.
// Depends on stl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stl_checker #(
    parameter int MAX_TOKEN_LEN = stl_pkg::MAX_TOKEN_LEN_DEF,
    parameter int LEN_W         = 7,
    parameter int POS_W         = 13
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [stl_pkg::KIND_W-1:0]  token_kind,
    input logic [LEN_W-1:0]            token_length,
    input logic [POS_W-1:0]            end_position,
    input logic                        truncated,
    input logic                        last
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_length) && $stable(end_position) && $stable(last))

    `ASSERT_IMPLIES(a_eof_shape, clk, rst_n, out_valid && (token_kind == stl_pkg::KIND_EOF), (token_length == '0) && !truncated && last)

    `ASSERT_IMPLIES(a_trunc_sat, clk, rst_n, out_valid && truncated, token_length == LEN_W'(MAX_TOKEN_LEN))

    `ASSERT_IMPLIES(a_flush_pair, clk, rst_n, out_valid && (token_kind == stl_pkg::KIND_UNTERM), !last)

endmodule

bind source_text_lexer_core stl_checker #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .LEN_W         (LEN_W),
    .POS_W         (POS_W)
) u_stl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_length (token_length),
    .end_position (end_position),
    .truncated    (truncated),
    .last         (last)
);
